/* rtl/core/ases_pkg.sv */
// Package for the angle sensor speed estimator.
// Holds sizes, constants, codes and payload structs; depends on nothing.
package ases_pkg;

	// Sensor resolution: a full turn is 2**ANGLE_BITS counts
	localparam int ANGLE_BITS = 12;
	localparam int DT_W       = 20;
	localparam int SPEED_W    = 32;
	localparam int POS_W      = 48;
	localparam int COUNT_W    = 32;
	localparam int ALPHA_W    = 16;
	localparam int APB_DW     = 64;
	localparam int APB_AW     = 4;

	// Signed step: range is plus/minus a half turn
	localparam int DELTA_W = ANGLE_BITS + 1;
	localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(1 << (ANGLE_BITS - 1));
	localparam logic signed [DELTA_W-1:0] TURN      = DELTA_W'(1 << ANGLE_BITS);

	// rpm in Q24.8 per count per microsecond: 60e6 * 256 / turn
	localparam logic [63:0] SPEED_K_FULL = 64'd15360000000 >> ANGLE_BITS;
	localparam int K_W = $clog2(SPEED_K_FULL + 64'd1);
	localparam logic [K_W-1:0] SPEED_K = K_W'(SPEED_K_FULL);

	// |step| never exceeds a half turn, so it fits in ANGLE_BITS
	localparam int MAG_W = ANGLE_BITS;
	localparam int QUO_W = MAG_W + K_W;

	// Filter product: unsigned alpha times signed 33-bit difference
	localparam int DIFF_W  = SPEED_W + 1;
	localparam int FPROD_W = ALPHA_W + 1 + DIFF_W;
	localparam int ADJ_W   = FPROD_W - ALPHA_W;
	localparam int SUM_W   = ADJ_W + 1;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(3277);

	// Magnet state codes
	localparam logic [1:0] MAG_OK     = 2'd0;
	localparam logic [1:0] MAG_NONE   = 2'd1;
	localparam logic [1:0] MAG_STRONG = 2'd2;
	localparam logic [1:0] MAG_WEAK   = 2'd3;

	// Register index, taken from paddr[3]
	localparam logic REG_ALPHA  = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle_count;
		logic                  read_ok;
		logic [1:0]            mag_code;
		logic [DT_W-1:0]       dt_us;
	} sample_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed_rpm;
		logic signed [POS_W-1:0]   position;
		logic                      sample_good;
		logic [COUNT_W-1:0]        sample_count;
	} result_t;

endpackage

/* rtl/core/ases_cfg.sv */
// APB-style configuration registers: filter alpha and position offset.
// Depends on ases_pkg.
module ases_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ases_pkg::APB_AW-1:0]   paddr,
	input  logic [ases_pkg::APB_DW-1:0]   pwdata,
	output logic [ases_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [ases_pkg::ALPHA_W-1:0]  alpha,
	output logic signed [ases_pkg::POS_W-1:0] offset
);
	import ases_pkg::*;

	logic                    wr_en;
	logic                    reg_sel;
	logic [ALPHA_W-1:0]      alpha_q;
	logic signed [POS_W-1:0] offset_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RESET;
			offset_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ALPHA:  alpha_q  <= pwdata[ALPHA_W-1:0];
				REG_OFFSET: offset_q <= pwdata[POS_W-1:0];
				default:    alpha_q  <= alpha_q;
			endcase
		end
	end

	// Read mux; offset is sign-extended to the bus width
	always_comb begin
		unique case (reg_sel)
			REG_ALPHA:  prdata = {{(APB_DW-ALPHA_W){1'b0}}, alpha_q};
			REG_OFFSET: prdata = {{(APB_DW-POS_W){offset_q[POS_W-1]}}, offset_q};
			default:    prdata = '0;
		endcase
	end

	assign alpha  = alpha_q;
	assign offset = offset_q;

endmodule

/* rtl/core/ases_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned QUO_W-bit dividend over DT_W-bit divisor; depends on ases_pkg.
module ases_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ases_pkg::QUO_W-1:0]  dividend,
	input  logic [ases_pkg::DT_W-1:0]   divisor,
	output logic                        done,
	output logic [ases_pkg::QUO_W-1:0]  quotient
);
	import ases_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DT_W-1:0]  rem_q;
	logic [DT_W-1:0]  dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic [DT_W:0]    trial;
	logic [DT_W:0]    trial_sub;
	logic             fits;

	// Shift in the next dividend bit and try the subtract
	assign trial     = {rem_q, quo_q[QUO_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = (trial >= {1'b0, dvs_q});

	// Control: count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/angle_sensor_speed_estimator_unit.sv */
// Angle sensor speed estimator, top level: sequencer, state and result register.
// Depends on ases_pkg, ases_cfg and ases_div.
//
//  channel   direction  handshake                  payload
//  sample    in         sample_valid/sample_ready  sample_t (angle, status, dt)
//  result    out        result_valid/result_ready  result_t (speed, position, count)
//  config    in         APB psel/penable/pready    alpha @0x0, offset @0x8
//
// A tracked sample passes, from accept to the next accept, through the accept,
// one multiply, the divide state (start, QUO_W = 34 quotient bits, done),
// a filter multiply, a filter add and the result load. Rejected and first
// samples go from the accept to the result load. sample_ready is high only
// in the idle state. Reset clears all estimator state. A stalled result holds
// its register; the sequencer waits in the done state until the register is free.
module angle_sensor_speed_estimator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  ases_pkg::sample_t             sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output ases_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ases_pkg::APB_AW-1:0]   paddr,
	input  logic [ases_pkg::APB_DW-1:0]   pwdata,
	output logic [ases_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import ases_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_FMUL,
		S_FADD,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [ALPHA_W-1:0]        alpha;
	logic signed [POS_W-1:0]   offset;

	// Estimator state
	logic [ANGLE_BITS-1:0]     last_angle_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic                      valid_q;
	logic signed [POS_W-1:0]   acc_q;
	logic [COUNT_W-1:0]        count_q;

	// Working registers
	logic [MAG_W-1:0]          mag_q;
	logic                      neg_q;
	logic [DT_W-1:0]           dt_q;
	logic [QUO_W-1:0]          prod_q;
	logic signed [SPEED_W-1:0] raw_q;
	logic signed [FPROD_W-1:0] fprod_q;
	logic                      div_start_q;
	logic                      result_valid_q;
	result_t                   result_q;

	logic                      accept;
	logic                      sample_ok;
	logic signed [DELTA_W-1:0] d_raw;
	logic signed [DELTA_W-1:0] d_wrap;
	logic [DELTA_W-1:0]        d_abs;
	logic                      div_done;
	logic [QUO_W-1:0]          quo;
	logic signed [SPEED_W-1:0] raw_sat;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [FPROD_W-1:0] fprod_rnd;
	logic signed [ADJ_W-1:0]   adj;
	logic signed [SUM_W-1:0]   speed_sum;
	logic signed [SPEED_W-1:0] speed_new;
	logic                      out_free;
	logic                      load_result;

	ases_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.alpha   (alpha),
		.offset  (offset)
	);

	ases_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign sample_ok    = sample.read_ok &&
	                      (sample.mag_code != MAG_NONE) &&
	                      (sample.mag_code != MAG_STRONG);

	// Angle step, wrapped to a half turn (exactly a half turn is kept)
	always_comb begin
		d_raw = $signed({1'b0, sample.angle_count}) - $signed({1'b0, last_angle_q});
		priority if (d_raw > HALF_TURN) begin
			d_wrap = d_raw - TURN;
		end else if (d_raw < -HALF_TURN) begin
			d_wrap = d_raw + TURN;
		end else begin
			d_wrap = d_raw;
		end
		d_abs = d_wrap[DELTA_W-1] ? DELTA_W'(-d_wrap) : DELTA_W'(d_wrap);
	end

	// Negate the quotient for a positive step and saturate to 32 bits
	always_comb begin
		if (neg_q) begin
			raw_sat = (quo > QUO_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quo);
		end else begin
			raw_sat = (quo > QUO_W'(SPEED_MAX) + QUO_W'(1)) ? SPEED_MIN
			                                               : SPEED_W'(-quo);
		end
	end

	// Low-pass filter: old + floor(alpha * (raw - old) / 2^16 + 0.5), saturated
	assign diff      = DIFF_W'(raw_q) - DIFF_W'(speed_q);
	assign fprod_rnd = fprod_q + FPROD_W'(32768);
	assign adj       = fprod_rnd[FPROD_W-1:ALPHA_W];
	assign speed_sum = SUM_W'(speed_q) + SUM_W'(adj);
	always_comb begin
		priority if (speed_sum > SUM_W'(SPEED_MAX)) begin
			speed_new = SPEED_MAX;
		end else if (speed_sum < SUM_W'(SPEED_MIN)) begin
			speed_new = SPEED_MIN;
		end else begin
			speed_new = speed_sum[SPEED_W-1:0];
		end
	end

	assign out_free    = !result_valid_q || result_ready;
	assign load_result = (state_q == S_DONE) && out_free;

	// Sequencer, estimator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_angle_q   <= '0;
			speed_q        <= '0;
			valid_q        <= 1'b0;
			acc_q          <= '0;
			count_q        <= '0;
			div_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
			mag_q          <= '0;
			neg_q          <= 1'b0;
			dt_q           <= '0;
			prod_q         <= '0;
			raw_q          <= '0;
			fprod_q        <= '0;
			result_q       <= '0;
		end else begin
			// Result valid: set on load, cleared when the transaction completes
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!sample_ok) begin
							speed_q <= '0;
							valid_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							last_angle_q <= sample.angle_count;
							count_q      <= count_q + COUNT_W'(1);
							valid_q      <= 1'b1;
							if (valid_q) begin
								acc_q   <= acc_q + POS_W'(d_wrap);
								mag_q   <= d_abs[MAG_W-1:0];
								neg_q   <= d_wrap[DELTA_W-1];
								dt_q    <= (sample.dt_us == '0) ? DT_W'(1)
								                                : sample.dt_us;
								state_q <= S_MUL;
							end else begin
								speed_q <= '0;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_MUL: begin
					prod_q      <= QUO_W'(mag_q) * QUO_W'(SPEED_K);
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						raw_q   <= raw_sat;
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					fprod_q <= FPROD_W'($signed({1'b0, alpha})) * FPROD_W'(diff);
					state_q <= S_FADD;
				end
				S_FADD: begin
					speed_q <= speed_new;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						result_q.speed_rpm    <= speed_q;
						result_q.position     <= acc_q - offset;
						result_q.sample_good  <= valid_q;
						result_q.sample_count <= count_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A rejected sample always reports zero speed
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sample_good |-> result.speed_rpm == '0)
		else $error("rejected sample reports nonzero speed");

	// Each usable sample bumps the count by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample_ok |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("sample count did not advance");

	// The divider only finishes while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

endmodule

/* dv/ases_checker.sv */
// Scoreboard for the angle sensor speed estimator: mirrors the APB registers,
// predicts one report per accepted sample and compares reports field by field.
// Depends on ases_pkg for the payload types, sizes and codes.
module ases_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_ready,
	input  ases_pkg::sample_t           sample,
	input  logic                        result_valid,
	input  logic                        result_ready,
	input  ases_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ases_pkg::APB_AW-1:0] paddr,
	input  logic [ases_pkg::APB_DW-1:0] pwdata,
	input  logic [ases_pkg::APB_DW-1:0] prdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          results_due
);
	import ases_pkg::*;

	localparam longint TURN_COUNTS = longint'(1) << ANGLE_BITS;
	localparam longint HALF_COUNTS = TURN_COUNTS / 2;
	// Q24.8 rpm per count per microsecond
	localparam longint RPM_GAIN    = longint'(64'd15360000000) / TURN_COUNTS;
	localparam longint SPEED_HI    = 64'sd2147483647;
	localparam longint SPEED_LO    = -SPEED_HI - 1;

	// Mirrored registers
	logic [ALPHA_W-1:0]        alpha_q;
	logic [POS_W-1:0]          offset_q;

	// Estimator state
	logic [ANGLE_BITS-1:0]     prev_angle;
	logic signed [SPEED_W-1:0] speed_q;
	logic                      tracking;
	logic [POS_W-1:0]          travel;
	logic [COUNT_W-1:0]        accepted;

	result_t                   reports_due[$];
	result_t                   forecast;
	logic                      offset_sel;

	function automatic logic signed [SPEED_W-1:0] clamp_speed(input longint v);
		if (v > SPEED_HI)
			return SPEED_W'(SPEED_HI);
		if (v < SPEED_LO)
			return SPEED_W'(SPEED_LO);
		return SPEED_W'(v);
	endfunction

	task automatic report_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Advance the estimator by one sample and form the report it should give
	task automatic estimate(input sample_t s, output result_t r);
		longint step;
		longint span;
		longint mag_q;
		longint raw;
		longint diff;
		logic   usable;
		usable = s.read_ok && (s.mag_code != MAG_NONE) && (s.mag_code != MAG_STRONG);
		if (!usable) begin
			speed_q  = '0;
			tracking = 1'b0;
		end else begin
			if (tracking) begin
				step = longint'(s.angle_count) - longint'(prev_angle);
				if (step > HALF_COUNTS)
					step -= TURN_COUNTS;
				else if (step < -HALF_COUNTS)
					step += TURN_COUNTS;
				span  = (s.dt_us == '0) ? 64'sd1 : longint'(s.dt_us);
				mag_q = ((step < 0) ? -step : step) * RPM_GAIN / span;
				// sensor direction is inverted: positive step means negative rpm
				raw   = clamp_speed((step < 0) ? mag_q : -mag_q);
				diff  = raw - longint'(speed_q);
				speed_q = clamp_speed(longint'(speed_q) +
					((longint'(alpha_q) * diff + 64'sd32768) >>> 16));
				travel = travel + POS_W'(step);
			end else begin
				speed_q = '0;
			end
			prev_angle = s.angle_count;
			accepted   = accepted + 1'b1;
			tracking   = 1'b1;
		end
		r.speed_rpm    = speed_q;
		r.position     = travel - offset_q;
		r.sample_good  = tracking;
		r.sample_count = accepted;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     = ALPHA_W'(3277);
			offset_q    = '0;
			prev_angle  = '0;
			speed_q     = '0;
			tracking    = 1'b0;
			travel      = '0;
			accepted    = '0;
			mismatches  = 0;
			results_due = 0;
			reports_due.delete();
		end else begin
			// Result transaction against the oldest prediction
			if (result_valid && result_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected report, expected none actual speed %0d count %0d",
						$time, result.speed_rpm, result.sample_count);
					mismatches++;
				end else begin
					forecast = reports_due.pop_front();
					report_field("speed_rpm", longint'(forecast.speed_rpm),
						longint'(result.speed_rpm));
					report_field("position", longint'(forecast.position),
						longint'(result.position));
					report_field("sample_good", longint'(forecast.sample_good),
						longint'(result.sample_good));
					report_field("sample_count", longint'(forecast.sample_count),
						longint'(result.sample_count));
				end
			end

			// APB access phase: writes update the mirror, reads are compared
			if (psel && penable && pready) begin
				offset_sel = (paddr[3] == REG_OFFSET);
				if (pwrite) begin
					if (offset_sel)
						offset_q = pwdata[POS_W-1:0];
					else
						alpha_q = pwdata[ALPHA_W-1:0];
				end else if (offset_sel) begin
					report_field("offset readback", longint'(offset_q),
						longint'(prdata[POS_W-1:0]));
				end else begin
					report_field("filter_alpha readback", longint'(alpha_q),
						longint'(prdata[ALPHA_W-1:0]));
				end
			end

			// Sample transaction
			if (sample_valid && sample_ready) begin
				estimate(sample, forecast);
				reports_due.push_back(forecast);
			end
			results_due = reports_due.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Testbench top for angle_sensor_speed_estimator_unit: clock, reset, APB setup,
// directed and random sample stimulus with idle/stall phases, and the verdict.
// Depends on ases_pkg, the block under test and ases_checker.
module tb_top;
	import ases_pkg::*;

	localparam logic [APB_AW-1:0] ALPHA_ADDR  = APB_AW'({REG_ALPHA, 3'b000});
	localparam logic [APB_AW-1:0] OFFSET_ADDR = APB_AW'({REG_OFFSET, 3'b000});
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 75;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	sample_t           sample;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                results_due;

	int                    idle_pct  = 0;
	int                    stall_pct = 0;
	logic [ANGLE_BITS-1:0] lead_angle;

	angle_sensor_speed_estimator_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ases_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.results_due  (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic sample_t mk(input int angle, input logic ok, input logic [1:0] mag,
		input int dt);
		sample_t s;
		s.angle_count = ANGLE_BITS'(angle);
		s.read_ok     = ok;
		s.mag_code    = mag;
		s.dt_us       = DT_W'(dt);
		return s;
	endfunction

	// One sample transaction; entered and left at a falling edge
	task automatic push_sample(input sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One APB transfer, setup then access, then idle with psel low before return
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Write both registers (junk in the unused upper bits) and read them back
	task automatic program_regs(input logic [ALPHA_W-1:0] alpha, input logic [POS_W-1:0] offs);
		logic [APB_DW-1:0] data;
		data = {$urandom, $urandom};
		data[ALPHA_W-1:0] = alpha;
		apb_access(1'b1, ALPHA_ADDR, data);
		data = {$urandom, $urandom};
		data[POS_W-1:0] = offs;
		apb_access(1'b1, OFFSET_ADDR, data);
		apb_access(1'b0, ALPHA_ADDR, {$urandom, $urandom});
		apb_access(1'b0, OFFSET_ADDR, {$urandom, $urandom});
	endtask

	// Wait until every report has come back and the block is idle
	task automatic settle();
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Mostly a plausibly moving rotor, some wild jumps and rejected reads
	task automatic draw_sample(output sample_t s);
		int pick;
		int step;
		int span_pick;
		pick      = $urandom_range(99);
		span_pick = $urandom_range(99);
		if (span_pick < 5)
			s.dt_us = '0;
		else if (span_pick < 20)
			s.dt_us = DT_W'($urandom_range(200, 1));
		else if (span_pick < 80)
			s.dt_us = DT_W'($urandom_range(5000, 200));
		else
			s.dt_us = DT_W'($urandom_range(20'hFFFFF, 0));
		if (pick < 10) begin
			s.angle_count = ANGLE_BITS'($urandom);
			case ($urandom_range(2))
				0: begin
					s.read_ok  = 1'b0;
					s.mag_code = 2'($urandom);
				end
				1: begin
					s.read_ok  = 1'b1;
					s.mag_code = MAG_NONE;
				end
				default: begin
					s.read_ok  = 1'b1;
					s.mag_code = MAG_STRONG;
				end
			endcase
		end else begin
			s.read_ok  = 1'b1;
			s.mag_code = ($urandom_range(3) == 0) ? MAG_WEAK : MAG_OK;
			if (pick < 25) begin
				s.angle_count = ANGLE_BITS'($urandom);
			end else begin
				if (pick < 32)
					step = int'($urandom_range(2056, 2040));
				else
					step = int'($urandom_range(64, 0));
				if ($urandom_range(1) == 0)
					step = -step;
				s.angle_count = lead_angle + ANGLE_BITS'(step);
			end
			lead_angle = s.angle_count;
		end
	endtask

	initial begin
		sample_t            s;
		logic [ALPHA_W-1:0] alpha;
		logic [POS_W-1:0]   offs;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		lead_angle   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed, reset register values
		push_sample(mk(100, 1'b0, MAG_OK, 1000));        // failed read
		push_sample(mk(200, 1'b1, MAG_NONE, 1000));      // magnet missing
		push_sample(mk(300, 1'b1, MAG_STRONG, 1000));    // magnet too strong
		push_sample(mk(0, 1'b1, MAG_OK, 1000));          // first accepted sample
		push_sample(mk(4095, 1'b1, MAG_WEAK, 1));        // wraps to -1, weak magnet usable
		push_sample(mk(2047, 1'b1, MAG_OK, 0));          // exactly minus half turn, zero dt
		push_sample(mk(4095, 1'b1, MAG_OK, 20'hFFFFF));  // exactly plus half turn, max dt
		push_sample(mk(0, 1'b1, MAG_OK, 1));             // wraps to +1
		push_sample(mk(2049, 1'b1, MAG_OK, 1));          // just past half turn
		push_sample(mk(2049, 1'b1, MAG_OK, 500));        // no motion
		push_sample(mk(2049, 1'b0, MAG_WEAK, 1));        // rejection clears speed
		push_sample(mk(10, 1'b1, MAG_WEAK, 20'hFFFFF));  // first after rejection
		push_sample(mk(4095, 1'b1, MAG_OK, 20'h55555));
		sample_valid <= 1'b0;
		settle();

		// Directed, full alpha and most negative offset: speed saturation both ways
		program_regs(16'hFFFF, 48'h8000_0000_0000);
		idle_pct  = 11;
		stall_pct = 11;
		push_sample(mk(0, 1'b1, MAG_OK, 1));
		push_sample(mk(2048, 1'b1, MAG_OK, 1));
		push_sample(mk(0, 1'b1, MAG_WEAK, 1));
		push_sample(mk(1, 1'b1, MAG_OK, 20'hAAAAA));
		sample_valid <= 1'b0;
		settle();

		// Random phases over register settings and handshake pressure
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: alpha = 16'h0000;
				1: alpha = 16'hFFFF;
				2: alpha = 16'd3277;
				3: alpha = 16'h0001;
				4: alpha = 16'h8000;
				5: alpha = 16'hFFFE;
				default: alpha = ALPHA_W'($urandom);
			endcase
			case (p)
				0: offs = 48'h7FFF_FFFF_FFFF;
				1: offs = 48'h8000_0000_0000;
				2: offs = '0;
				3: offs = '1;
				4: offs = 48'h0000_0000_0001;
				default: offs = POS_W'({$urandom, $urandom});
			endcase
			program_regs(alpha, offs);
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 67;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 67;
				end
				default: begin
					idle_pct  = 11;
					stall_pct = 11;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				draw_sample(s);
				push_sample(s);
			end
			sample_valid <= 1'b0;
			settle();
		end

		repeat (64) @(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
